// File: hw/rtl/heat_stencil_1d_sweep_unit_defines.svh
// ----------------------------------------------------------------------------
// heat stencil sweep unit assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef HEAT_STENCIL_1D_SWEEP_UNIT_DEFINES_SVH
`define HEAT_STENCIL_1D_SWEEP_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define HSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition that must never be seen out of reset
`define HSU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HSU_ASSERT(lbl, prop, msg)
`define HSU_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: hw/rtl/hsu_pkg.sv
// ----------------------------------------------------------------------------
// hsu_pkg
// shared widths, register codes and payload types of the heat stencil unit
// ----------------------------------------------------------------------------
package hsu_pkg;

  // field and arithmetic widths
  localparam int unsigned INDEX_BITS    = 20;
  localparam int unsigned TEMP_BITS     = 16;
  localparam int unsigned COEF_BITS     = 16;
  localparam int unsigned FRAC_BITS     = COEF_BITS;
  localparam int unsigned DIFF_BITS     = TEMP_BITS + 2;
  localparam int unsigned TOT_BITS      = TEMP_BITS + COEF_BITS + 3;
  localparam int unsigned CFG_DATA_BITS = (INDEX_BITS > COEF_BITS) ? INDEX_BITS : COEF_BITS;
  localparam int unsigned CFG_IDX_BITS  = 2;

  // job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [INDEX_BITS-1:0] SOURCE_RESET = '0;
  localparam logic [COEF_BITS-1:0]  COEF_RESET   = COEF_BITS'(13107);

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SOURCE_POSITION       = 2'd0,
    REG_DIFFUSION_COEFFICIENT = 2'd1
  } cfg_reg_e;

  // input request
  typedef struct packed {
    logic [TEMP_BITS-1:0] temperature_in;
    logic                 last_in;
  } in_t;

  // result request
  typedef struct packed {
    logic [TEMP_BITS-1:0] temperature_out;
    logic                 last_out;
  } out_t;

  // one stencil job handed from front to back
  typedef struct packed {
    logic [TEMP_BITS-1:0] left;
    logic [TEMP_BITS-1:0] centre;
    logic [TEMP_BITS-1:0] right;
    logic                 hold;
    logic                 last;
  } job_t;

  // front status seen by the top level
  typedef struct packed {
    logic busy;
    logic pending;
  } front_status_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

// File: hw/rtl/hsu_front.sv
// ----------------------------------------------------------------------------
// hsu_front
// accepts cells, keeps the three-cell window and issues stencil jobs
// ----------------------------------------------------------------------------
module hsu_front import hsu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  input  logic [INDEX_BITS-1:0] source_position_i,
  input  queue_status_t         q_status_i,
  output logic                  push_o,
  output job_t                  push_job_o,
  output front_status_t         status_o
);

  typedef enum logic [2:0] {
    WIN_EMPTY = 3'b001,
    WIN_FIRST = 3'b010,
    WIN_FULL  = 3'b100
  } win_e;

  win_e                  win_q, win_d;
  logic [TEMP_BITS-1:0]  prior_q, prior_d;
  logic [TEMP_BITS-1:0]  held_q, held_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic                  pending_q, pending_d;
  job_t                  pend_job_q, pend_job_d;

  logic                  accept;
  logic [TEMP_BITS-1:0]  x;
  logic [TEMP_BITS-1:0]  left;
  logic [INDEX_BITS-1:0] idx_next;
  logic                  job_valid;
  job_t                  job;

  // a full queue stalls input; during a flush only a single-cell row must wait,
  // since the first cell of a longer row pushes no job
  assign in_stall_o = q_status_i.full || (pending_q && in_data_i.last_in);
  assign accept     = in_valid_i && !in_stall_o;
  assign x          = in_data_i.temperature_in;
  assign idx_next   = idx_q + INDEX_BITS'(1);

  // window update and job formation
  always_comb begin
    win_d      = win_q;
    prior_d    = prior_q;
    held_d     = held_q;
    idx_d      = idx_q;
    pending_d  = pending_q;
    pend_job_d = pend_job_q;
    job_valid  = 1'b0;
    job        = '0;
    left       = held_q;

    if (pending_q && !q_status_i.full) begin
      pending_d = 1'b0;
    end

    if (accept) begin
      unique case (win_q)
        WIN_EMPTY: begin
          if (in_data_i.last_in) begin
            // single-cell row: all neighbours are the cell itself
            job_valid = 1'b1;
            job       = '{left: x, centre: x, right: x,
                          hold: (source_position_i == '0), last: 1'b1};
          end else begin
            held_d = x;
            idx_d  = '0;
            win_d  = WIN_FIRST;
          end
        end
        WIN_FIRST, WIN_FULL: begin
          left      = (win_q == WIN_FIRST) ? held_q : prior_q;
          job_valid = 1'b1;
          job       = '{left: left, centre: held_q, right: x,
                        hold: (idx_q == source_position_i), last: 1'b0};
          prior_d   = held_q;
          held_d    = x;
          idx_d     = idx_next;
          win_d     = WIN_FULL;
          if (in_data_i.last_in) begin
            // right end: hold the final cell's flush job as pending
            pending_d  = 1'b1;
            pend_job_d = '{left: held_q, centre: x, right: x,
                           hold: (idx_next == source_position_i), last: 1'b1};
            prior_d    = '0;
            held_d     = '0;
            idx_d      = '0;
            win_d      = WIN_EMPTY;
          end
        end
        default: begin
          win_d = WIN_EMPTY;
        end
      endcase
    end
  end

  // queue write: pending flush first, else the fresh job
  assign push_o     = pending_q ? !q_status_i.full : job_valid;
  assign push_job_o = pending_q ? pend_job_q : job;

  assign status_o.busy    = (win_q != WIN_EMPTY);
  assign status_o.pending = pending_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= WIN_EMPTY;
      prior_q   <= '0;
      held_q    <= '0;
      idx_q     <= '0;
      pending_q <= 1'b0;
    end else begin
      win_q     <= win_d;
      prior_q   <= prior_d;
      held_q    <= held_d;
      idx_q     <= idx_d;
      pending_q <= pending_d;
    end
  end

  // pending job payload
  always_ff @(posedge clk_i) begin
    pend_job_q <= pend_job_d;
  end

endmodule

// File: hw/rtl/hsu_queue.sv
// ----------------------------------------------------------------------------
// hsu_queue
// short job queue decoupling window front from arithmetic back
// ----------------------------------------------------------------------------
module hsu_queue import hsu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  job_t          push_job_i,
  input  logic          pop_i,
  output job_t          pop_job_o,
  output queue_status_t status_o
);

  job_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign status_o.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign status_o.valid = (count_q != '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign pop_job_o      = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// File: hw/rtl/hsu_back.sv
// ----------------------------------------------------------------------------
// hsu_back
// two-stage stencil arithmetic: multiply, then round and saturate
// ----------------------------------------------------------------------------
module hsu_back import hsu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  queue_status_t        q_status_i,
  input  job_t                 job_i,
  output logic                 pop_o,
  input  logic [COEF_BITS-1:0] coef_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o
);

  localparam logic signed [TOT_BITS-1:0] ROUND_HALF = TOT_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [TEMP_BITS+1:0]       TEMP_MAX   = {2'b00, {TEMP_BITS{1'b1}}};

  logic                        s1_valid_q;
  logic signed [TOT_BITS-1:0]  prod_q;
  logic [TEMP_BITS-1:0]        centre_q;
  logic                        hold_q;
  logic                        last_q;
  logic                        out_valid_q;
  out_t                        out_q;

  logic                        s1_adv;
  logic                        s1_load;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [COEF_BITS:0]   coef_s;
  logic signed [TOT_BITS-1:0]  prod_d;
  logic signed [TOT_BITS-1:0]  total;
  logic [TEMP_BITS+1:0]        upper;
  logic [TEMP_BITS-1:0]        res;

  // pipeline flow
  assign s1_adv  = !out_valid_q || !out_stall_i;
  assign s1_load = !s1_valid_q || s1_adv;
  assign pop_o   = q_status_i.valid && s1_load;

  // stage one: neighbour difference times coefficient
  assign diff   = $signed({2'b00, job_i.left}) + $signed({2'b00, job_i.right})
                - $signed({1'b0, job_i.centre, 1'b0});
  assign coef_s = $signed({1'b0, coef_i});
  assign prod_d = coef_s * diff;

  // stage two: add centre, round to nearest, clamp to field range; a held cell keeps its centre
  assign total = $signed({3'b000, centre_q, {FRAC_BITS{1'b0}}}) + prod_q + ROUND_HALF;
  assign upper = total[TOT_BITS-2:FRAC_BITS];

  always_comb begin
    if (hold_q) begin
      res = centre_q;
    end else if (total[TOT_BITS-1]) begin
      res = '0;
    end else if (upper > TEMP_MAX) begin
      res = '1;
    end else begin
      res = upper[TEMP_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= q_status_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      prod_q   <= prod_d;
      centre_q <= job_i.centre;
      hold_q   <= job_i.hold;
      last_q   <= job_i.last;
    end
    if (s1_adv && s1_valid_q) begin
      out_q.temperature_out <= res;
      out_q.last_out        <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/heat_stencil_1d_sweep_unit.sv
// result path: job queue, stage-one register, output register, after the edge that
//   accepts the cell to its right; a row's final job comes from the pending flush register
// throughput: one cell per cycle while the job queue is not full; a single-cell row right
//   after a row end also waits while the row-end flush holds the job queue write port
// reset: asynchronous, active low; window and queue empty, source position 0,
//   diffusion coefficient 0.2 in Q0.16
// ----------------------------------------------------------------------------
// heat_stencil_1d_sweep_unit
// one sweep of a three-point heat stencil over a streamed temperature row
// ----------------------------------------------------------------------------
`include "heat_stencil_1d_sweep_unit_defines.svh"

module heat_stencil_1d_sweep_unit import hsu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_t                      in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_t                     out_data_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  logic [INDEX_BITS-1:0] source_q;
  logic [COEF_BITS-1:0]  coef_q;
  logic                  push;
  job_t                  push_job;
  logic                  pop;
  job_t                  pop_job;
  queue_status_t         q_status;
  front_status_t         f_status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= SOURCE_RESET;
      coef_q   <= COEF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SOURCE_POSITION:       source_q <= cfg_wdata_i[INDEX_BITS-1:0];
        REG_DIFFUSION_COEFFICIENT: coef_q   <= cfg_wdata_i[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  hsu_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_data_i         (in_data_i),
    .source_position_i (source_q),
    .q_status_i        (q_status),
    .push_o            (push),
    .push_job_o        (push_job),
    .status_o          (f_status)
  );

  hsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .status_o   (q_status)
  );

  hsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .job_i       (pop_job),
    .pop_o       (pop),
    .coef_i      (coef_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // checks
  `HSU_ASSERT_NEVER(a_no_push_when_full, push && q_status.full, "job pushed into full queue")
  `HSU_ASSERT(a_flush_queued, in_valid_i && !in_stall_o && in_data_i.last_in && f_status.busy |=> f_status.pending, "row-end flush not queued")
  `HSU_ASSERT(a_coef_write, cfg_we_i && (cfg_index_i == REG_DIFFUSION_COEFFICIENT) |=> coef_q == $past(cfg_wdata_i[COEF_BITS-1:0]), "coefficient write lost")

endmodule
